[hdl/imh_pkg.sv]
// Package with the request and result types, command and status codes, and sequencer states.
`default_nettype none
package imh_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  node_id;
    logic [15:0] key_value;
  } imh_req_t;

  typedef struct packed {
    logic [7:0]  top_node;
    logic [15:0] top_key;
    logic [8:0]  heap_count;
    logic [1:0]  status;
  } imh_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_POP_WAIT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP,
    S_WRITE,
    S_ROOT_RD,
    S_ROOT_CAP,
    S_RESULT
  } imh_state_t;

endpackage
`default_nettype wire

[hdl/imh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imh_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/indexed_min_heap_unit.sv]
// Indexed binary min-heap of node ids with a node-to-slot table and a sift sequencer.
// A request sifts up or down the heap level by level; one memory read port sets the pace.
// One request is worked at a time; a finished result waits in the output register.
// After reset the slot table is cleared before the first request.
// Reset empties the heap; heap and key contents stay undefined until written.
`default_nettype none
module indexed_min_heap_unit
  import imh_pkg::*;
#(
  parameter int NODES    = 256,
  parameter int KEY_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire imh_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output imh_rsp_t      rsp
);
  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int EW = KEY_BITS + 8;
  localparam logic [16:0] NODE_LIMIT = 17'(NODES);
  localparam logic [CW-1:0] COUNT_MAX = CW'(NODES);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  imh_state_t state, state_next;
  logic [1:0] cmd, cmd_next;
  logic [7:0] node, node_next;
  logic [KEY_BITS-1:0] key, key_next;
  logic [EW-1:0] cur, cur_next;
  logic [EW-1:0] lent, lent_next;
  logic [IW-1:0] pos, pos_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] clr, clr_next;
  logic [1:0] status, status_next;
  logic [7:0] rep_node, rep_node_next;
  logic [KEY_BITS-1:0] rep_key, rep_key_next;
  imh_rsp_t rsp_next;
  logic rsp_valid_next;

  logic heap_we, slot_we;
  logic [IW-1:0] heap_waddr, heap_raddr, slot_waddr, slot_raddr;
  logic [EW-1:0] heap_wdata, heap_rdata;
  logic [CW-1:0] slot_wdata, slot_rdata;

  logic [CW:0] left, right, count_x;
  logic [IW-1:0] left_idx, right_idx;
  logic [KEY_BITS-1:0] cur_k, lk, rk, hk;

  imh_ram #(.W(EW), .D(NODES)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  imh_ram #(.W(CW), .D(NODES)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  assign left      = (CW + 1)'({pos, 1'b1});
  assign right     = left + (CW + 1)'(1);
  assign count_x   = (CW + 1)'(count);
  assign left_idx  = IW'(left);
  assign right_idx = IW'(right);
  assign cur_k     = cur[EW-1:8];
  assign lk        = lent[EW-1:8];
  assign rk        = heap_rdata[EW-1:8];
  assign hk        = heap_rdata[EW-1:8];
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      count     <= '0;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      clr       <= clr_next;
      rsp_valid <= rsp_valid_next;
    end
    cmd      <= cmd_next;
    node     <= node_next;
    key      <= key_next;
    cur      <= cur_next;
    lent     <= lent_next;
    pos      <= pos_next;
    status   <= status_next;
    rep_node <= rep_node_next;
    rep_key  <= rep_key_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    node_next      = node;
    key_next       = key;
    cur_next       = cur;
    lent_next      = lent;
    pos_next       = pos;
    count_next     = count;
    clr_next       = clr;
    status_next    = status;
    rep_node_next  = rep_node;
    rep_key_next   = rep_key;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    heap_we        = 1'b0;
    heap_waddr     = pos;
    heap_wdata     = cur;
    heap_raddr     = '0;
    slot_we        = 1'b0;
    slot_waddr     = IW'(cur[7:0]);
    slot_wdata     = CW'(pos) + CW'(1);
    slot_raddr     = IW'(req.node_id);

    case (state)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr;
        slot_wdata = '0;
        clr_next   = clr + IW'(1);
        if (clr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd_next    = req.cmd;
          node_next   = req.node_id;
          key_next    = KEY_BITS'(req.key_value);
          status_next = ST_OK;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cur_next = {key, node};
        case (cmd)
          CMD_INSERT: begin
            if ({9'd0, node} >= NODE_LIMIT || slot_rdata != '0 || count >= COUNT_MAX) begin
              status_next = ST_PRESENT;
              state_next  = S_ROOT_RD;
            end else begin
              pos_next   = IW'(count);
              count_next = count + CW'(1);
              state_next = S_UP_RD;
            end
          end
          CMD_UPDATE: begin
            if ({9'd0, node} >= NODE_LIMIT || slot_rdata == '0) begin
              status_next = ST_ABSENT;
              state_next  = S_ROOT_RD;
            end else begin
              pos_next   = IW'(slot_rdata - CW'(1));
              state_next = S_UP_RD;
            end
          end
          CMD_POP: begin
            if (count == '0) begin
              status_next   = ST_EMPTY;
              rep_node_next = '0;
              rep_key_next  = '0;
              state_next    = S_RESULT;
            end else begin
              rep_node_next = heap_rdata[7:0];
              rep_key_next  = hk;
              slot_we       = 1'b1;
              slot_waddr    = IW'(heap_rdata[7:0]);
              slot_wdata    = '0;
              count_next    = count - CW'(1);
              pos_next      = '0;
              heap_raddr    = IW'(count - CW'(1));
              if (count == CW'(1)) begin
                state_next = S_RESULT;
              end else begin
                state_next = S_POP_WAIT;
              end
            end
          end
          default: begin
            state_next = S_ROOT_RD;
          end
        endcase
      end
      S_POP_WAIT: begin
        cur_next   = heap_rdata;
        state_next = S_DN_RD;
      end
      S_UP_RD: begin
        heap_raddr = (pos - IW'(1)) >> 1;
        if (pos == '0) begin
          state_next = (cmd == CMD_UPDATE) ? S_DN_RD : S_WRITE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (hk > cur_k) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          slot_we    = 1'b1;
          slot_waddr = IW'(heap_rdata[7:0]);
          pos_next   = (pos - IW'(1)) >> 1;
          state_next = S_UP_RD;
        end else begin
          state_next = (cmd == CMD_UPDATE) ? S_DN_RD : S_WRITE;
        end
      end
      S_DN_RD: begin
        heap_raddr = left_idx;
        if (right > count_x) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lent_next  = heap_rdata;
        heap_raddr = right_idx;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        state_next = S_WRITE;
        if (right == count_x) begin
          if (cur_k > lk) begin
            heap_we    = 1'b1;
            heap_wdata = lent;
            slot_we    = 1'b1;
            slot_waddr = IW'(lent[7:0]);
            pos_next   = left_idx;
          end
        end else if (cur_k > lk && lk <= rk) begin
          heap_we    = 1'b1;
          heap_wdata = lent;
          slot_we    = 1'b1;
          slot_waddr = IW'(lent[7:0]);
          pos_next   = left_idx;
          state_next = S_DN_RD;
        end else if (cur_k > rk && rk < lk) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          slot_we    = 1'b1;
          slot_waddr = IW'(heap_rdata[7:0]);
          pos_next   = right_idx;
          state_next = S_DN_RD;
        end
      end
      S_WRITE: begin
        heap_we    = 1'b1;
        slot_we    = 1'b1;
        state_next = (cmd == CMD_POP) ? S_RESULT : S_ROOT_RD;
      end
      S_ROOT_RD: begin
        heap_raddr = '0;
        state_next = S_ROOT_CAP;
      end
      S_ROOT_CAP: begin
        if (count == '0) begin
          rep_node_next = '0;
          rep_key_next  = '0;
        end else begin
          rep_node_next = heap_rdata[7:0];
          rep_key_next  = hk;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.top_node   = rep_node;
          rsp_next.top_key    = 16'(rep_key);
          rsp_next.heap_count = 9'(count);
          rsp_next.status     = status;
          rsp_valid_next      = 1'b1;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire
